>>> design/sps_pkg.sv
// shared types and constants for the sensor packet status parser
package sps_pkg;

	// packet id bytes
	localparam logic [7:0] ID_LID      = 8'h10;
	localparam logic [7:0] ID_PRESSURE = 8'h20;
	localparam logic [7:0] ID_TEMP     = 8'h30;
	localparam logic [7:0] ID_BATTERY  = 8'h40;
	localparam logic [7:0] ID_AIR      = 8'h50;

	// reported sensor kinds
	localparam logic [2:0] KIND_LID      = 3'd0;
	localparam logic [2:0] KIND_PRESSURE = 3'd1;
	localparam logic [2:0] KIND_TEMP     = 3'd2;
	localparam logic [2:0] KIND_BATTERY  = 3'd3;
	localparam logic [2:0] KIND_AIR      = 3'd4;
	localparam logic [2:0] KIND_IDLE     = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_PRESSURE_LIMIT = 2'd0;
	localparam logic [1:0] REG_TEMP_LIMIT     = 2'd1;
	localparam logic [1:0] REG_BATT_LOW_PCT   = 2'd2;
	localparam logic [1:0] REG_AIR_CODE       = 2'd3;

	// configuration reset values
	localparam logic [15:0] PRESSURE_LIMIT_RST = 16'd60000;
	localparam logic [15:0] TEMP_LIMIT_RST     = 16'd60000;
	localparam logic [6:0]  BATT_LOW_PCT_RST   = 7'd5;
	localparam logic [7:0]  AIR_CODE_RST       = 8'h22;

	// percent = value * 100 / 60000 = value / 600, done as (value * PCT_MUL) >> PCT_SHIFT
	// exact over all 16-bit values since 65535 * (PCT_MUL * 600 - 2**26) < 2**26
	localparam int          PCT_SHIFT = 26;
	localparam logic [16:0] PCT_MUL   = 17'd111849;
	localparam logic [6:0]  PCT_MAX   = 7'd109;

	typedef struct packed {
		logic [2:0] sensor_kind;
		logic       lid_fault;
		logic       pressure_panic;
		logic       temperature_panic;
		logic       on_battery;
		logic       battery_low;
		logic       air_in_line;
		logic [6:0] battery_percent;
	} status_word_t;

endpackage

>>> design/sensor_packet_status_parser.sv
// sensor packet status parser: packet assembly, sticky flags and result buffering
// a closing word's result is registered in the output word, or the skid word
// throughput: one stream word per cycle unless stream_stall is high; the output
//   register plus one skid word absorb a result while the result side stalls
// reset: arst_n clears packet state, flags, battery level and output valids,
//   and loads the register defaults
module sensor_packet_status_parser
	import sps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       stream_valid,
	output logic       stream_stall,
	input  logic [7:0] stream_byte,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,

	output logic       status_valid,
	input  logic       status_stall,
	output logic [2:0] sensor_kind,
	output logic       lid_fault,
	output logic       pressure_panic,
	output logic       temperature_panic,
	output logic       on_battery,
	output logic       battery_low,
	output logic       air_in_line,
	output logic [6:0] battery_percent
);

	logic [15:0] pressure_limit_q;
	logic [15:0] temperature_limit_q;
	logic [6:0]  batt_low_pct_q;
	logic [7:0]  air_code_q;

	logic [2:0]  kind_q;
	logic [1:0]  left_q;
	logic [15:0] acc_q;
	logic        lid_q, press_q, temp_q, onbatt_q, battlow_q, air_q;
	logic [6:0]  level_q;

	logic         out_valid_q;
	status_word_t out_q;
	logic         skid_valid_q;
	status_word_t skid_q;

	logic         accept;
	logic         finish;
	logic         emit;
	logic         out_take;
	logic [2:0]   kind_d;
	logic [1:0]   left_d;
	logic [15:0]  acc_d;
	logic [15:0]  reading;
	logic [32:0]  pct_prod;
	logic [6:0]   pct;
	status_word_t res;

	assign cfg_ready    = 1'b1;
	assign stream_stall = skid_valid_q;
	assign accept       = stream_valid && !skid_valid_q;
	assign out_take     = out_valid_q && !status_stall;

	// big-endian reading of a two-byte packet closed by this word
	assign reading  = {acc_q[7:0], stream_byte};
	assign pct_prod = acc_q * PCT_MUL;
	assign pct      = pct_prod[PCT_SHIFT +: 7];

	assign finish = (left_q == 2'd1);
	assign emit   = accept && finish;

	always_comb begin
		kind_d = kind_q;
		left_d = left_q;
		acc_d  = acc_q;
		if (left_q == 2'd0) begin
			acc_d = '0;
			case (stream_byte)
				ID_LID: begin
					kind_d = KIND_LID;
					left_d = 2'd1;
				end
				ID_PRESSURE: begin
					kind_d = KIND_PRESSURE;
					left_d = 2'd2;
				end
				ID_TEMP: begin
					kind_d = KIND_TEMP;
					left_d = 2'd2;
				end
				ID_BATTERY: begin
					kind_d = KIND_BATTERY;
					left_d = 2'd3;
				end
				ID_AIR: begin
					kind_d = KIND_AIR;
					left_d = 2'd1;
				end
				default: begin
					kind_d = KIND_IDLE;
					left_d = 2'd0;
				end
			endcase
		end else if (finish) begin
			kind_d = KIND_IDLE;
			left_d = 2'd0;
			acc_d  = '0;
		end else begin
			acc_d  = {acc_q[7:0], stream_byte};
			left_d = left_q - 2'd1;
		end
	end

	// flags as they stand after the closing word
	always_comb begin
		res.sensor_kind       = kind_q;
		res.lid_fault         = lid_q;
		res.pressure_panic    = press_q;
		res.temperature_panic = temp_q;
		res.on_battery        = onbatt_q;
		res.battery_low       = battlow_q;
		res.air_in_line       = air_q;
		res.battery_percent   = level_q;
		case (kind_q)
			KIND_LID: res.lid_fault = (stream_byte == 8'd0);
			KIND_PRESSURE: res.pressure_panic = (reading > pressure_limit_q);
			KIND_TEMP: res.temperature_panic = (reading > temperature_limit_q);
			KIND_BATTERY: begin
				res.battery_percent = pct;
				res.on_battery      = (stream_byte != 8'd0);
				res.battery_low     = (pct <= batt_low_pct_q);
			end
			default: res.air_in_line = (stream_byte == air_code_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressure_limit_q    <= PRESSURE_LIMIT_RST;
			temperature_limit_q <= TEMP_LIMIT_RST;
			batt_low_pct_q      <= BATT_LOW_PCT_RST;
			air_code_q          <= AIR_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRESSURE_LIMIT: pressure_limit_q <= cfg_data;
				REG_TEMP_LIMIT: temperature_limit_q <= cfg_data;
				REG_BATT_LOW_PCT: batt_low_pct_q <= cfg_data[6:0];
				REG_AIR_CODE: air_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= KIND_IDLE;
			left_q    <= 2'd0;
			acc_q     <= '0;
			lid_q     <= 1'b0;
			press_q   <= 1'b0;
			temp_q    <= 1'b0;
			onbatt_q  <= 1'b0;
			battlow_q <= 1'b0;
			air_q     <= 1'b0;
			level_q   <= '0;
		end else if (accept) begin
			kind_q <= kind_d;
			left_q <= left_d;
			acc_q  <= acc_d;
			if (finish) begin
				lid_q     <= res.lid_fault;
				press_q   <= res.pressure_panic;
				temp_q    <= res.temperature_panic;
				onbatt_q  <= res.on_battery;
				battlow_q <= res.battery_low;
				air_q     <= res.air_in_line;
				level_q   <= res.battery_percent;
			end
		end
	end

	// output register with one skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= skid_valid_q || emit;
				skid_valid_q <= 1'b0;
			end else if (emit) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (emit) begin
				out_q <= res;
			end
		end else if (emit) begin
			skid_q <= res;
		end
	end

	assign status_valid      = out_valid_q;
	assign sensor_kind       = out_q.sensor_kind;
	assign lid_fault         = out_q.lid_fault;
	assign pressure_panic    = out_q.pressure_panic;
	assign temperature_panic = out_q.temperature_panic;
	assign on_battery        = out_q.on_battery;
	assign battery_low       = out_q.battery_low;
	assign air_in_line       = out_q.air_in_line;
	assign battery_percent   = out_q.battery_percent;

endmodule

>>> design/sps_checker.sv
// port-level checks for the sensor packet status parser, bound to the top level
module sps_checker
	import sps_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       stream_stall,
	input logic       status_valid,
	input logic       status_stall,
	input logic [2:0] sensor_kind,
	input logic       lid_fault,
	input logic       battery_low,
	input logic [6:0] battery_percent
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status_stall |=> status_valid && $stable(sensor_kind)
			&& $stable(battery_percent) && $stable(lid_fault) && $stable(battery_low))
		else $error("stalled status word changed");

	// only completed packets of known kinds are reported
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> sensor_kind <= KIND_AIR)
		else $error("status word with unknown sensor kind");

	a_pct: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> battery_percent <= PCT_MAX)
		else $error("battery percent out of range");

	// the stream is held back only behind a full, stalled result side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stream_stall |-> status_valid && $past(status_stall))
		else $error("stream stalled without a blocked result");

endmodule

bind sensor_packet_status_parser sps_checker u_sps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.stream_stall    (stream_stall),
	.status_valid    (status_valid),
	.status_stall    (status_stall),
	.sensor_kind     (sensor_kind),
	.lid_fault       (lid_fault),
	.battery_low     (battery_low),
	.battery_percent (battery_percent)
);
